// File: rtl/pdc_pkg.sv
package pdc_pkg;

	localparam int TableDepth = 1024;
	localparam int IdxW = $clog2(TableDepth);
	localparam int AngleBits = 16;
	localparam int CordicSteps = 28;
	localparam int CordicW = 32;
	localparam logic signed [CordicW-1:0] CordicStart = 32'sd163008219;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [1:0] REG_PP = 2'd0;
	localparam logic [1:0] REG_PD = 2'd1;
	localparam logic [1:0] REG_LP = 2'd2;
	localparam logic [1:0] REG_LD = 2'd3;

	typedef struct packed {
		logic opcode;
		logic [9:0] ref_index;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
		logic [15:0] heading;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] speed_drive;
		logic signed [47:0] steer_drive;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic [15:0] heading;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		logic signed [CordicW-1:0] cos_v;
		logic signed [CordicW-1:0] sin_v;
	} cordic_rsp_t;

	function automatic logic signed [CordicW-1:0] atan_turn(input logic [4:0] i);
		logic signed [CordicW-1:0] r;
		case (i)
			5'd0: r = 32'sd536870912;
			5'd1: r = 32'sd316933406;
			5'd2: r = 32'sd167458907;
			5'd3: r = 32'sd85004756;
			5'd4: r = 32'sd43150659;
			5'd5: r = 32'sd21354465;
			5'd6: r = 32'sd10745374;
			5'd7: r = 32'sd5340245;
			5'd8: r = 32'sd2670163;
			5'd9: r = 32'sd1335087;
			5'd10: r = 32'sd667544;
			5'd11: r = 32'sd333772;
			5'd12: r = 32'sd166886;
			5'd13: r = 32'sd83443;
			5'd14: r = 32'sd41722;
			5'd15: r = 32'sd20861;
			5'd16: r = 32'sd10430;
			5'd17: r = 32'sd5215;
			5'd18: r = 32'sd2608;
			5'd19: r = 32'sd1304;
			5'd20: r = 32'sd652;
			5'd21: r = 32'sd326;
			5'd22: r = 32'sd163;
			5'd23: r = 32'sd81;
			5'd24: r = 32'sd41;
			5'd25: r = 32'sd20;
			5'd26: r = 32'sd10;
			5'd27: r = 32'sd5;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/pdc_ram.sv
module pdc_ram #(
	parameter int Width = 64,
	parameter int Depth = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/pdc_cordic.sv
module pdc_cordic
	import pdc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cordic_req_t req,
	output cordic_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	logic [4:0] step_q;
	logic flip_q;
	logic signed [CordicW-1:0] x_q, y_q, z_q;
	logic [31:0] a_full;
	logic [31:0] a_rot;
	logic flip_n;
	logic signed [CordicW-1:0] xs, ys;

	always_comb begin
		a_full = {req.heading[AngleBits-1:0], {(32-AngleBits){1'b0}}};
		flip_n = (a_full[31:30] == 2'd1) || (a_full[31:30] == 2'd2);
		a_rot = flip_n ? (a_full + 32'h8000_0000) : a_full;
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 5'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= CordicStart;
			y_q <= '0;
			z_q <= $signed(a_rot);
			flip_q <= flip_n;
		end else if (busy_q) begin
			if (!z_q[CordicW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_turn(step_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_turn(step_q);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.cos_v = flip_q ? -x_q : x_q;
	assign rsp.sin_v = flip_q ? -y_q : y_q;

endmodule

// File: rtl/path_tracking_pd_controller_top.sv
// Two-axis PD path-tracking controller.
// Input channel (in_valid/in_ready/in_data): opcode 0 loads a reference
// point into the 1024-entry table, opcode 1 runs one control step against
// the named entry with the vehicle position and heading.
// Output channel (out_valid/out_ready/out_data): one speed/steer request per
// step; loads produce nothing.
// Gains are written through cfg_we/cfg_index/cfg_data; the user must do so
// only while idle, as the block does not enforce it. A load writes the table
// as it is taken. A step raises out_valid after a table read, the CORDIC
// unit (start plus 28 iterations), eight products through one 33x33 multiplier
// interleaved with the rounding and saturation stages, and the output
// register. The next request is taken once that register is loaded.
// One item is in flight at a time; the result sits in an output register,
// and the next item is taken while that register still waits for the sink.
// A stalled sink holds the result and, once a second step finishes, holds
// the block until the first result is taken.
// Reset restores gains 500/1000/4000/4000 and clears the previous errors;
// the table is not cleared and must be loaded before it is tracked.
module path_tracking_pd_controller_top
	import pdc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_ROT = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_ERR = 3'd4;
	localparam logic [2:0] ST_DRV = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	logic [2:0] state_q;
	logic [3:0] mcnt_q;
	logic [15:0] pp_q, pd_q, lp_q, ld_q;
	logic signed [31:0] prev_p_q, prev_l_q;
	in_item_t item_q;
	logic [63:0] rdata;
	logic signed [32:0] dx_q, dy_q;
	logic signed [31:0] cos_q, sin_q;
	logic signed [65:0] prod_s1;
	logic signed [67:0] acc_q;
	logic signed [31:0] ep_q, el_q;
	logic signed [32:0] dp_q, dl_q;
	logic signed [50:0] drv_acc_q;
	logic signed [47:0] speed_q;
	cordic_req_t creq;
	cordic_rsp_t crsp;
	logic signed [32:0] ma;
	logic signed [32:0] mb;
	logic signed [67:0] rnd;
	logic signed [31:0] err_sat;
	logic signed [47:0] drv_sat;
	logic accept;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	pdc_ram #(.Width(64), .Depth(TableDepth)) u_table (
		.clk(clk),
		.we(accept && in_data.opcode == OP_LOAD),
		.waddr(in_data.ref_index[IdxW-1:0]),
		.wdata({in_data.y_value, in_data.x_value}),
		.raddr(in_data.ref_index[IdxW-1:0]),
		.rdata(rdata)
	);

	assign creq.start = (state_q == ST_READ);
	assign creq.heading = item_q.heading;

	pdc_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.req(creq),
		.rsp(crsp)
	);

	// operand select for the shared multiplier
	always_comb begin
		case (mcnt_q)
			4'd0: begin ma = dx_q; mb = 33'(cos_q); end
			4'd1: begin ma = -dy_q; mb = 33'(sin_q); end
			4'd2: begin ma = dx_q; mb = 33'(sin_q); end
			4'd3: begin ma = dy_q; mb = 33'(cos_q); end
			4'd4: begin ma = 33'(ep_q); mb = {17'd0, pp_q}; end
			4'd5: begin ma = dp_q; mb = {17'd0, pd_q}; end
			4'd6: begin ma = 33'(el_q); mb = {17'd0, lp_q}; end
			4'd7: begin ma = dl_q; mb = {17'd0, ld_q}; end
			default: begin ma = '0; mb = '0; end
		endcase
		rnd = (acc_q + 68'sd134217728) >>> 28;
		if (rnd > 68'sd2147483647) err_sat = 32'h7fff_ffff;
		else if (rnd < -68'sd2147483648) err_sat = 32'h8000_0000;
		else err_sat = rnd[31:0];
		if (drv_acc_q > 51'sd140737488355327) drv_sat = {1'b0, {47{1'b1}}};
		else if (drv_acc_q < -51'sd140737488355328) drv_sat = {1'b1, 47'd0};
		else drv_sat = drv_acc_q[47:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mcnt_q <= '0;
			pp_q <= 16'd500;
			pd_q <= 16'd1000;
			lp_q <= 16'd4000;
			ld_q <= 16'd4000;
			prev_p_q <= '0;
			prev_l_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PP: pp_q <= cfg_data;
					REG_PD: pd_q <= cfg_data;
					REG_LP: lp_q <= cfg_data;
					REG_LD: ld_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_OUT && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (accept && in_data.opcode == OP_STEP) state_q <= ST_READ;
				ST_READ: state_q <= ST_ROT;
				ST_ROT: if (crsp.done) begin
					state_q <= ST_MUL;
					mcnt_q <= '0;
				end
				ST_MUL: begin
					// products are registered before they are summed; the sum closes after each pair
					mcnt_q <= mcnt_q + 4'd1;
					if (mcnt_q == 4'd2 || mcnt_q == 4'd4) state_q <= ST_ERR;
					if (mcnt_q == 4'd6 || mcnt_q == 4'd8) state_q <= ST_DRV;
				end
				ST_ERR: begin
					if (mcnt_q == 4'd3) begin
						prev_p_q <= err_sat;
					end else begin
						prev_l_q <= err_sat;
					end
					state_q <= ST_MUL;
				end
				ST_DRV: begin
					if (mcnt_q == 4'd9) state_q <= ST_OUT;
					else state_q <= ST_MUL;
				end
				ST_OUT: if (!out_valid || out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= in_data;
		if (state_q == ST_READ) begin
			dx_q <= 33'(signed'(rdata[31:0])) - 33'(item_q.x_value);
			dy_q <= 33'(item_q.y_value) - 33'(signed'(rdata[63:32]));
		end
		if (state_q == ST_ROT && crsp.done) begin
			cos_q <= crsp.cos_v;
			sin_q <= crsp.sin_v;
		end
		// hold the pending product across the error and drive stages
		if (state_q == ST_MUL) prod_s1 <= ma * mb;
		case (state_q)
			ST_MUL: begin
				if (mcnt_q == 4'd1 || mcnt_q == 4'd3 || mcnt_q == 4'd5
						|| mcnt_q == 4'd7) begin
					acc_q <= 68'(prod_s1);
					drv_acc_q <= 51'(prod_s1);
				end else begin
					acc_q <= acc_q + 68'(prod_s1);
					drv_acc_q <= drv_acc_q + 51'(prod_s1);
				end
			end
			ST_ERR: begin
				if (mcnt_q == 4'd3) begin
					ep_q <= err_sat;
					dp_q <= 33'(err_sat) - 33'(prev_p_q);
				end else begin
					el_q <= err_sat;
					dl_q <= 33'(err_sat) - 33'(prev_l_q);
				end
			end
			ST_DRV: begin
				if (mcnt_q == 4'd7) speed_q <= drv_sat;
			end
			ST_OUT: begin
				if (!out_valid || out_ready)
					out_data <= '{speed_drive: speed_q, steer_drive: drv_sat};
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready)
		else $error("request taken while busy");
	a_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		crsp.done |-> state_q == ST_ROT)
		else $error("rotation finished outside its phase");
`endif

endmodule
